// File: design/max_heap_priority_queue_defines.svh
// Assertion macros shared by the checker of the max-heap priority queue.
// Expects clk_i and rst_ni in the scope that uses them.
`ifndef MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// Concurrent assertion sampled on clk_i, off while reset is asserted.
`define MHPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent assertion sampled on clk_i, also checked during reset.
`define MHPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: design/mhpq_pkg.sv
// Shared types and constants of the max-heap priority queue.
// No dependencies; used by mhpq_ctrl, the top level and the checker.
`default_nettype none

package mhpq_pkg;

  localparam int unsigned CAPACITY  = 64;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned IDX_W     = $clog2(CAPACITY);
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
  localparam int unsigned CHD_W     = IDX_W + 2;
  localparam int unsigned OUT_CNT_W = 7;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef struct packed {
    status_e              status;
    key_t                 removed;
    key_t                 top;
    logic                 top_valid;
    logic [OUT_CNT_W-1:0] count;
  } result_t;

endpackage

`default_nettype wire

// File: design/mhpq_ram.sv
// Generic single-write, dual-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module mhpq_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0_i,
  output logic      [WIDTH-1:0]         rdata0_o,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic      [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem[raddr0_i];
    rdata1_o <= mem[raddr1_i];
  end

endmodule

`default_nettype wire

// File: design/mhpq_ctrl.sv
// Sequencer of the max-heap priority queue: insert sift-up, delete sift-down.
// Depends on mhpq_pkg; owns the heap RAM instance (mhpq_ram).
`default_nettype none

module mhpq_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             op_i,
  input  wire mhpq_pkg::key_t   value_i,
  output logic                  res_valid_o,
  input  wire logic             res_take_i,
  output mhpq_pkg::result_t     res_o
);
  import mhpq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_UP_CMP,
    S_LAST,
    S_LAST_W,
    S_DN,
    S_DN_CMP,
    S_OUT
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  key_t             key_q, key_d;
  key_t             root_q, root_d;
  key_t             removed_q, removed_d;
  status_e          status_q, status_d;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr0, raddr1;
  key_t             wdata, rdata0, rdata1;

  logic [IDX_W-1:0] parent;
  logic [CHD_W-1:0] left, right, n_ext;
  logic             l_ok, r_ok, take_l, take_r;
  key_t             cand;

  mhpq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_W)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr0_i (raddr0),
    .rdata0_o (rdata0),
    .raddr1_i (raddr1),
    .rdata1_o (rdata1)
  );

  assign parent = (pos_q - IDX_W'(1)) >> 1;
  assign left   = {1'b0, pos_q, 1'b1};
  assign right  = left + CHD_W'(1);
  assign n_ext  = CHD_W'(count_q);
  assign l_ok   = left < n_ext;
  assign r_ok   = right < n_ext;
  assign take_l = l_ok && (rdata0 > key_q);
  assign cand   = take_l ? rdata0 : key_q;
  assign take_r = r_ok && (rdata1 > cand);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    key_d       = key_q;
    removed_d   = removed_q;
    status_d    = status_q;
    we          = 1'b0;
    waddr       = pos_q;
    wdata       = key_q;
    raddr0      = parent;
    raddr1      = '0;
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          removed_d = '0;
          status_d  = ST_DONE;
          if (op_i == OP_INSERT) begin
            if (count_q == CNT_W'(CAPACITY)) begin
              status_d = ST_FULL;
              state_d  = S_OUT;
            end else begin
              key_d   = value_i;
              pos_d   = IDX_W'(count_q);
              count_d = count_q + CNT_W'(1);
              state_d = S_UP;
            end
          end else begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_OUT;
            end else begin
              removed_d = root_q;
              count_d   = count_q - CNT_W'(1);
              state_d   = (count_q == CNT_W'(1)) ? S_OUT : S_LAST;
            end
          end
        end
      end
      S_UP: begin
        if (pos_q == '0) begin
          we      = 1'b1;
          state_d = S_OUT;
        end else begin
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (key_q > rdata0) begin
          wdata   = rdata0;
          pos_d   = parent;
          state_d = S_UP;
        end else begin
          state_d = S_OUT;
        end
      end
      S_LAST: begin
        raddr0  = IDX_W'(count_q);
        state_d = S_LAST_W;
      end
      S_LAST_W: begin
        key_d   = rdata0;
        pos_d   = '0;
        state_d = S_DN;
      end
      S_DN: begin
        raddr0 = left[IDX_W-1:0];
        raddr1 = right[IDX_W-1:0];
        if (!l_ok) begin
          we      = 1'b1;
          state_d = S_OUT;
        end else begin
          state_d = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (take_r) begin
          wdata   = rdata1;
          pos_d   = right[IDX_W-1:0];
          state_d = S_DN;
        end else if (take_l) begin
          wdata   = rdata0;
          pos_d   = left[IDX_W-1:0];
          state_d = S_DN;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Mirror entry zero so the top key is known without a RAM read.
  assign root_d = (we && waddr == '0) ? wdata : root_q;

  assign in_stall_o          = (state_q != S_IDLE);
  assign res_o.status        = status_q;
  assign res_o.removed       = removed_q;
  assign res_o.top           = (count_q != '0) ? root_q : '0;
  assign res_o.top_valid     = (count_q != '0);
  assign res_o.count         = OUT_CNT_W'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      pos_q     <= '0;
      key_q     <= '0;
      root_q    <= '0;
      removed_q <= '0;
      status_q  <= ST_DONE;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      pos_q     <= pos_d;
      key_q     <= key_d;
      root_q    <= root_d;
      removed_q <= removed_d;
      status_q  <= status_d;
    end
  end

endmodule

`default_nettype wire

// File: design/max_heap_priority_queue.sv
// Binary max-heap priority queue of signed 32-bit keys, up to CAPACITY (64) keys, held in
// one synchronous RAM with a registered read. An insert (op 0) places the key in the hole at
// the end and walks it up; a delete-max (op 1) returns the root, takes the last key into the
// root hole and walks it down, swapping with the larger child while that child is strictly
// larger (left on a tie). Every accepted item gives exactly one result: status (0 done,
// 1 rejected full, 2 rejected empty), removed key, top key, top valid and key count after the
// operation. Items are worked one at a time; each heap level takes a RAM read state and a
// compare-and-write state, since the store has a single write port; a rejected item goes
// straight to the result state. One result may wait in the output register while the next
// item is taken in. No clearing pass runs after reset: only entries below the count are
// read.
// Depends on mhpq_pkg, mhpq_ctrl and mhpq_ram.
`default_nettype none

module max_heap_priority_queue (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // input channel
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           op_i,
  input  wire logic signed [mhpq_pkg::KEY_W-1:0] value_i,
  // result channel
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [1:0]                          status_o,
  output logic signed [mhpq_pkg::KEY_W-1:0]   removed_value_o,
  output logic signed [mhpq_pkg::KEY_W-1:0]   top_value_o,
  output logic                                top_valid_o,
  output logic [mhpq_pkg::OUT_CNT_W-1:0]      count_o
);
  import mhpq_pkg::*;

  logic    res_valid;
  logic    res_take;
  result_t res;

  logic    out_valid_q, out_valid_d;
  result_t out_res_q, out_res_d;

  mhpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .value_i     (value_i),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res)
  );

  // Load a finished result when the output slot is empty or being transferred this cycle.
  assign res_take = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (res_valid && res_take) begin
      out_valid_d = 1'b1;
      out_res_d   = res;
    end else if (out_valid_q && !out_stall_i) begin
      // drop the slot once its transfer completes
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      out_res_q   <= out_res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_res_q.status;
  assign removed_value_o = out_res_q.removed;
  assign top_value_o     = out_res_q.top;
  assign top_valid_o     = out_res_q.top_valid;
  assign count_o         = out_res_q.count;

endmodule

`default_nettype wire

// File: design/mhpq_checker.sv
// Port-level checker for the max-heap priority queue, bound to the top level.
// Depends on mhpq_pkg and max_heap_priority_queue_defines.svh.
`default_nettype none

`include "max_heap_priority_queue_defines.svh"

module mhpq_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              out_valid_o,
  input wire logic                              out_stall_i,
  input wire logic [1:0]                        status_o,
  input wire logic signed [mhpq_pkg::KEY_W-1:0] removed_value_o,
  input wire logic signed [mhpq_pkg::KEY_W-1:0] top_value_o,
  input wire logic                              top_valid_o,
  input wire logic [mhpq_pkg::OUT_CNT_W-1:0]    count_o
);
  import mhpq_pkg::*;

  `MHPQ_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(removed_value_o) && $stable(top_value_o) && $stable(count_o), "stalled result changed")

  `MHPQ_ASSERT(a_top_valid_count, out_valid_o |-> (top_valid_o == (count_o != '0)), "top_valid disagrees with count")

  `MHPQ_ASSERT(a_empty_top_zero, out_valid_o && !top_valid_o |-> top_value_o == '0, "empty heap shows a top key")

  `MHPQ_ASSERT(a_reject_empty, out_valid_o && status_o == ST_EMPTY |-> count_o == '0 && removed_value_o == '0, "empty rejection with keys or removed key")

  // Reset clears the output slot asynchronously, so check in the cycle after reset is seen.
  `MHPQ_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o, "result valid during reset")

endmodule

bind max_heap_priority_queue mhpq_checker u_checker (.*);

`default_nettype wire
